// File: design/lrci_pkg.sv
// shared constants and types of the line rasteriser with colour interpolation
package lrci_pkg;

    localparam int LRCI_MAX_SCREEN   = 64;
    localparam int LRCI_SCREEN_RESET = 64;

    localparam int COORD_W = 9;   // endpoint coordinate width
    localparam int COLOR_W = 8;   // colour width
    localparam int SCR_W   = 7;   // screen size register width
    localparam int PIX_W   = 6;   // pixel coordinate width
    localparam int DIV_W   = 9;   // divider operand width
    localparam int DIV_CW  = $clog2(DIV_W);

    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 24;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quo;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

endpackage

// File: design/lrci_div.sv
// restoring divider, one quotient bit per cycle
module lrci_div
    import lrci_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [DIV_CW-1:0] r_cnt, n_cnt;
    logic [DIV_W-1:0]  r_rem, n_rem;
    logic [DIV_W-1:0]  r_quo, n_quo;
    logic [DIV_W-1:0]  r_dvs, n_dvs;

    logic [DIV_W:0]    rem_sh;
    logic              ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[DIV_W-1]};
        ge     = rem_sh >= {1'b0, r_dvs};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvs  = r_dvs;
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_rem  = '0;
            n_quo  = i_req.dividend;
            n_dvs  = i_req.divisor;
        end else if (r_busy) begin
            n_rem = ge ? DIV_W'(rem_sh - {1'b0, r_dvs}) : rem_sh[DIV_W-1:0];
            n_quo = {r_quo[DIV_W-2:0], ge};
            n_cnt = DIV_CW'(r_cnt + 1'b1);
            if (r_cnt == DIV_CW'(DIV_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvs <= n_dvs;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;
    assign o_rsp.rem  = r_rem;

endmodule

// File: design/line_rasterizer_color_interp_core.sv
// top level: line rasteriser stepping the major axis with exact colour interpolation
// sequence after a line is taken: prep, two divisions on the shared divider, one step
//   per major-axis position, one flush; a zero-length line skips the divisions
// flow: one line at a time, input ready only while the sequencer idles;
//   output stalls hold the stepping and the flush
// reset: synchronous active-low, sequencer idle, no item held, screen size back to 64
module line_rasterizer_color_interp_core
    import lrci_pkg::*;
#(
    parameter int MAX_SCREEN = LRCI_MAX_SCREEN
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration: screen size
    input  logic                  i_cfg_wen,
    input  logic [SCR_W-1:0]      i_cfg_wdata,
    // line input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // start_x[8:0], start_y[17:9], end_x[26:18], end_y[35:27],
    // start_color[43:36], end_color[51:44], zero fill
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // pixel output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pixel_x[5:0], pixel_y[11:6], pixel_color[19:12], zero fill
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast      // last_pixel
);

    typedef enum logic [7:0] {
        S_IDLE      = 8'b0000_0001,
        S_PREP      = 8'b0000_0010,
        S_DIVN_GO   = 8'b0000_0100,
        S_DIVN_WAIT = 8'b0000_1000,
        S_DIVC_GO   = 8'b0001_0000,
        S_DIVC_WAIT = 8'b0010_0000,
        S_STEP      = 8'b0100_0000,
        S_FLUSH     = 8'b1000_0000
    } t_state;

    localparam int QW = COORD_W + 1;   // signed width of quotients and differences

    t_state r_state, n_state;
    logic [SCR_W-1:0] r_screen, n_screen;

    // raw endpoints as accepted
    logic signed [COORD_W-1:0] r_ax, r_ay, r_bx, r_by, n_ax, n_ay, n_bx, n_by;
    logic [COLOR_W-1:0]        r_ca, r_cb, n_ca, n_cb;

    // ordered line
    logic                      r_steep, n_steep;
    logic signed [COORD_W-1:0] r_m, r_m1, r_n0, r_n1, n_m, n_m1, n_n0, n_n1;
    logic [COLOR_W-1:0]        r_c0, r_c1, n_c0, n_c1;
    logic [COORD_W-1:0]        r_span, n_span;

    // floor-form quotient and remainder walkers for minor and colour
    logic signed [QW-1:0]  r_qn, r_dqn, r_qc, r_dqc, n_qn, n_dqn, n_qc, n_dqc;
    logic [COORD_W-1:0]    r_rn, r_drn, r_rc, r_drc, n_rn, n_drn, n_rc, n_drc;

    // pending pixel (held until we know whether it is the last one) and output register
    logic             r_pv, n_pv;
    logic [PIX_W-1:0] r_px, r_py, n_px, n_py;
    logic [COLOR_W-1:0] r_pc, n_pc;
    logic             r_ov, n_ov;
    logic [PIX_W-1:0] r_ox, r_oy, n_ox, n_oy;
    logic [COLOR_W-1:0] r_oc, n_oc;
    logic             r_ol, n_ol;

    t_div_req div_req;
    t_div_rsp div_rsp;

    // prep datapath
    logic signed [QW-1:0]      dx, dy;
    logic [COORD_W-1:0]        adx, ady;
    logic                      steep;
    logic signed [COORD_W-1:0] sm0, sn0, sm1, sn1;
    logic                      swap;

    // division fix-up
    logic signed [QW-1:0] dn, dc;
    logic                 dneg;
    logic signed [QW-1:0] fq;
    logic [COORD_W-1:0]   fr;

    // stepping datapath
    logic [COORD_W:0]     rsn, rsc;
    logic                 wrapn, wrapc;
    logic signed [QW-1:0] minor_t;
    logic [SCR_W-1:0]     dim;
    logic                 vis;
    logic                 out_free;
    logic                 stall;
    logic [PIX_W-1:0]     cx, cy;

    lrci_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        // major axis choice and ordering; equal spans stay not steep
        dx    = QW'(r_bx) - QW'(r_ax);
        dy    = QW'(r_by) - QW'(r_ay);
        adx   = dx[QW-1] ? COORD_W'(-dx) : COORD_W'(dx);
        ady   = dy[QW-1] ? COORD_W'(-dy) : COORD_W'(dy);
        steep = adx < ady;
        sm0   = steep ? r_ay : r_ax;
        sn0   = steep ? r_ax : r_ay;
        sm1   = steep ? r_by : r_bx;
        sn1   = steep ? r_bx : r_by;
        swap  = sm1 < sm0;

        // per-step increments: floor division of the end-to-end difference by span
        dn   = QW'(r_n1) - QW'(r_n0);
        dc   = QW'({1'b0, r_c1}) - QW'({1'b0, r_c0});
        dneg = r_state[3] ? dn[QW-1] : dc[QW-1];
        if (!dneg) begin
            fq = QW'({1'b0, div_rsp.quo});
            fr = div_rsp.rem;
        end else if (div_rsp.rem != '0) begin
            fq = ~QW'({1'b0, div_rsp.quo});
            fr = COORD_W'(r_span - div_rsp.rem);
        end else begin
            fq = QW'(-QW'({1'b0, div_rsp.quo}));
            fr = '0;
        end

        // one step of each walker: remainder stays below span, one compare and subtract
        rsn   = {1'b0, r_rn} + {1'b0, r_drn};
        rsc   = {1'b0, r_rc} + {1'b0, r_drc};
        wrapn = rsn >= {1'b0, r_span};
        wrapc = rsc >= {1'b0, r_span};

        // truncation toward zero from the floor form
        minor_t = r_qn + QW'((r_qn[QW-1] && (r_rn != '0)) ? 1 : 0);

        dim = (r_screen > SCR_W'(MAX_SCREEN)) ? SCR_W'(MAX_SCREEN) : r_screen;
        vis = !r_m[COORD_W-1] && (r_m[COORD_W-2:0] < {1'b0, dim})
            && !minor_t[QW-1] && (minor_t[QW-2:0] < {2'b0, dim});
        cx  = r_steep ? minor_t[PIX_W-1:0] : r_m[PIX_W-1:0];
        cy  = r_steep ? r_m[PIX_W-1:0] : minor_t[PIX_W-1:0];

        out_free = !r_ov || m_axis_tready;
        stall    = vis && r_pv && !out_free;
    end

    always_comb begin
        n_state  = r_state;
        n_screen = i_cfg_wen ? i_cfg_wdata : r_screen;
        n_ax = r_ax; n_ay = r_ay; n_bx = r_bx; n_by = r_by;
        n_ca = r_ca; n_cb = r_cb;
        n_steep = r_steep;
        n_m = r_m; n_m1 = r_m1; n_n0 = r_n0; n_n1 = r_n1;
        n_c0 = r_c0; n_c1 = r_c1; n_span = r_span;
        n_qn = r_qn; n_rn = r_rn; n_dqn = r_dqn; n_drn = r_drn;
        n_qc = r_qc; n_rc = r_rc; n_dqc = r_dqc; n_drc = r_drc;
        n_pv = r_pv; n_px = r_px; n_py = r_py; n_pc = r_pc;
        n_ov = r_ov && !m_axis_tready;
        n_ox = r_ox; n_oy = r_oy; n_oc = r_oc; n_ol = r_ol;

        div_req.start    = 1'b0;
        div_req.dividend = r_state[2] ? (dn[QW-1] ? COORD_W'(-dn) : COORD_W'(dn))
                                      : (dc[QW-1] ? COORD_W'(-dc) : COORD_W'(dc));
        div_req.divisor  = r_span;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_ax    = s_axis_tdata[8:0];
                    n_ay    = s_axis_tdata[17:9];
                    n_bx    = s_axis_tdata[26:18];
                    n_by    = s_axis_tdata[35:27];
                    n_ca    = s_axis_tdata[43:36];
                    n_cb    = s_axis_tdata[51:44];
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                n_steep = steep;
                n_m     = swap ? sm1 : sm0;
                n_m1    = swap ? sm0 : sm1;
                n_n0    = swap ? sn1 : sn0;
                n_n1    = swap ? sn0 : sn1;
                n_c0    = swap ? r_cb : r_ca;
                n_c1    = swap ? r_ca : r_cb;
                n_span  = steep ? ady : adx;
                // walkers start exact at the first endpoint
                n_qn    = QW'(swap ? sn1 : sn0);
                n_qc    = QW'({1'b0, swap ? r_cb : r_ca});
                n_rn    = '0;
                n_rc    = '0;
                n_dqn   = '0;
                n_drn   = '0;
                n_dqc   = '0;
                n_drc   = '0;
                // zero-length line: single start point, no division
                n_state = ((steep ? ady : adx) == '0) ? S_STEP : S_DIVN_GO;
            end
            S_DIVN_GO: begin
                div_req.start = 1'b1;
                n_state       = S_DIVN_WAIT;
            end
            S_DIVN_WAIT: begin
                if (div_rsp.done) begin
                    n_dqn   = fq;
                    n_drn   = fr;
                    n_state = S_DIVC_GO;
                end
            end
            S_DIVC_GO: begin
                div_req.start = 1'b1;
                n_state       = S_DIVC_WAIT;
            end
            S_DIVC_WAIT: begin
                if (div_rsp.done) begin
                    n_dqc   = fq;
                    n_drc   = fr;
                    n_state = S_STEP;
                end
            end
            S_STEP: begin
                if (!stall) begin
                    if (vis) begin
                        if (r_pv) begin
                            n_ov = 1'b1;
                            n_ox = r_px;
                            n_oy = r_py;
                            n_oc = r_pc;
                            n_ol = 1'b0;
                        end
                        n_pv = 1'b1;
                        n_px = cx;
                        n_py = cy;
                        n_pc = r_qc[COLOR_W-1:0];
                    end
                    if (r_m == r_m1) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_m  = COORD_W'(r_m + 1'b1);
                        n_rn = wrapn ? COORD_W'(rsn - {1'b0, r_span}) : rsn[COORD_W-1:0];
                        n_rc = wrapc ? COORD_W'(rsc - {1'b0, r_span}) : rsc[COORD_W-1:0];
                        n_qn = r_qn + r_dqn + QW'(wrapn ? 1 : 0);
                        n_qc = r_qc + r_dqc + QW'(wrapc ? 1 : 0);
                    end
                end
            end
            S_FLUSH: begin
                // the held pixel is the last visible one
                if (!r_pv) begin
                    n_state = S_IDLE;
                end else if (out_free) begin
                    n_ov    = 1'b1;
                    n_ox    = r_px;
                    n_oy    = r_py;
                    n_oc    = r_pc;
                    n_ol    = 1'b1;
                    n_pv    = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_screen <= SCR_W'(LRCI_SCREEN_RESET);
            r_pv     <= 1'b0;
            r_ov     <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_screen <= n_screen;
            r_pv     <= n_pv;
            r_ov     <= n_ov;
        end
        r_ax <= n_ax; r_ay <= n_ay; r_bx <= n_bx; r_by <= n_by;
        r_ca <= n_ca; r_cb <= n_cb;
        r_steep <= n_steep;
        r_m <= n_m; r_m1 <= n_m1; r_n0 <= n_n0; r_n1 <= n_n1;
        r_c0 <= n_c0; r_c1 <= n_c1; r_span <= n_span;
        r_qn <= n_qn; r_rn <= n_rn; r_dqn <= n_dqn; r_drn <= n_drn;
        r_qc <= n_qc; r_rc <= n_rc; r_dqc <= n_dqc; r_drc <= n_drc;
        r_px <= n_px; r_py <= n_py; r_pc <= n_pc;
        r_ox <= n_ox; r_oy <= n_oy; r_oc <= n_oc; r_ol <= n_ol;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {4'b0, r_oc, r_oy, r_ox};
    assign m_axis_tlast  = r_ol;

endmodule

// File: dv/testbench.sv
// self-checking testbench of the line rasteriser with colour interpolation
module testbench;
    import lrci_pkg::*;

    // timing of the run
    localparam int SETTLE_CYCLES  = 600;   // longest line plus prep and flush
    localparam int HOLD_CYCLES    = 300;   // long receiver hold-off under pressure
    localparam int WATCHDOG_LIMIT = 4000;  // cycles with no item moving on either side
    localparam int N_PHASES       = 8;
    localparam int PHASE_ITEMS    = 20;

    // screen size of each random phase, last entry replaced by a random size
    localparam int SCREEN_PLAN [N_PHASES] = '{64, 1, 127, 0, 37, 2, 64, 0};

    // one line as it sits in s_axis_tdata, start_x in the lowest bits
    typedef struct packed {
        logic [COLOR_W-1:0] end_color;
        logic [COLOR_W-1:0] start_color;
        logic [COORD_W-1:0] end_y;
        logic [COORD_W-1:0] end_x;
        logic [COORD_W-1:0] start_y;
        logic [COORD_W-1:0] start_x;
    } line_t;

    // one pixel as it leaves the block
    typedef struct packed {
        logic               last;
        logic [COLOR_W-1:0] color;
        logic [PIX_W-1:0]   y;
        logic [PIX_W-1:0]   x;
    } pixel_t;

    // rasterises each accepted line on its own copy of the screen size and
    // matches the pixels coming out against what it predicted, in order
    class pixel_scoreboard;
        int unsigned screen_size;
        pixel_t      pixels_due[$];
        int          errors;
        int          lines_seen;
        int          lines_blank;
        int          pixels_checked;

        function new();
            screen_size    = LRCI_SCREEN_RESET;
            errors         = 0;
            lines_seen     = 0;
            lines_blank    = 0;
            pixels_checked = 0;
        endfunction

        function void set_screen(int unsigned value);
            screen_size = value & 32'h7f;
        endfunction

        function int pending();
            return pixels_due.size();
        endfunction

        // steps the major axis and keeps the visible pixels of the line
        function void note_line(line_t ln);
            int     maj0, min0, maj1, min1, col0, col1;
            int     span, wa, wb, minor, colour, dim, tmp, m;
            bit     steep;
            pixel_t px;
            pixel_t row[$];

            maj0 = int'($signed(ln.start_x));
            min0 = int'($signed(ln.start_y));
            maj1 = int'($signed(ln.end_x));
            min1 = int'($signed(ln.end_y));
            col0 = int'(ln.start_color);
            col1 = int'(ln.end_color);
            dim  = (screen_size > LRCI_MAX_SCREEN) ? LRCI_MAX_SCREEN : screen_size;
            steep = 1'b0;

            // steep line: rows become the major axis, equal spans stay shallow
            if (((maj1 > maj0) ? maj1 - maj0 : maj0 - maj1) <
                ((min1 > min0) ? min1 - min0 : min0 - min1)) begin
                tmp = maj0; maj0 = min0; min0 = tmp;
                tmp = maj1; maj1 = min1; min1 = tmp;
                steep = 1'b1;
            end
            // order the endpoints so the major coordinate rises, colours follow
            if (maj1 < maj0) begin
                tmp = maj0; maj0 = maj1; maj1 = tmp;
                tmp = min0; min0 = min1; min1 = tmp;
                tmp = col0; col0 = col1; col1 = tmp;
            end

            span = maj1 - maj0;
            for (m = maj0; m <= maj1; m++) begin
                if (span == 0) begin
                    // zero-length line: the start point with its own colour
                    minor  = min0;
                    colour = col0;
                end else begin
                    // integer division truncates toward zero, as the block must
                    wa     = maj1 - m;
                    wb     = m - maj0;
                    minor  = (min0 * wa + min1 * wb) / span;
                    colour = (col0 * wa + col1 * wb) / span;
                end
                if (m >= 0 && m < dim && minor >= 0 && minor < dim && row.size() < 64) begin
                    px.x     = steep ? minor[PIX_W-1:0] : m[PIX_W-1:0];
                    px.y     = steep ? m[PIX_W-1:0] : minor[PIX_W-1:0];
                    px.color = colour[COLOR_W-1:0];
                    px.last  = 1'b0;
                    row.push_back(px);
                end
            end

            lines_seen++;
            if (row.size() == 0) begin
                lines_blank++;
            end else begin
                row[row.size()-1].last = 1'b1;
            end
            foreach (row[i]) pixels_due.push_back(row[i]);
        endfunction

        function void check_pixel(pixel_t got);
            pixel_t want;
            if (pixels_due.size() == 0) begin
                errors++;
                $display("%0t: pixel x=%0d y=%0d colour=%0d last=%0b with none expected",
                         $time, got.x, got.y, got.color, got.last);
                return;
            end
            want = pixels_due.pop_front();
            pixels_checked++;
            if (got !== want) begin
                errors++;
                $display("%0t: pixel mismatch, expected x=%0d y=%0d colour=%0d last=%0b, ",
                         $time, want.x, want.y, want.color, want.last,
                         "got x=%0d y=%0d colour=%0d last=%0b",
                         got.x, got.y, got.color, got.last);
            end
        endfunction
    endclass

    // block ports, every input known from time zero
    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_wen     = 1'b0;
    logic [SCR_W-1:0]      i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // start_x, start_y, end_x, end_y, start_color, end_color, zero fill
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // pixel_x, pixel_y, pixel_color, zero fill
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  m_axis_tlast;

    pixel_scoreboard sb = new();

    // shared between the sender and the receiver
    bit hold_req   = 1'b0;   // asks the receiver for one long hold-off
    bit gaps_on    = 1'b1;   // sender may idle between lines
    bit quiet_tail = 1'b0;   // last part of the run, no idling on either side
    int screens_tried = 0;

    line_rasterizer_color_interp_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // offer one line, optionally after a short idle burst, and hold it until taken;
    // tvalid stays high on return so back-to-back lines need no extra nba
    task automatic send_line(line_t ln);
        int gap;
        if (gaps_on && !quiet_tail && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 10);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_DATA_W - $bits(line_t)){1'b0}}, ln};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_line(ln);
    endtask

    task automatic send_coords(int sx, int sy, int ex, int ey, int c0, int c1);
        line_t ln;
        ln.start_x     = sx[COORD_W-1:0];
        ln.start_y     = sy[COORD_W-1:0];
        ln.end_x       = ex[COORD_W-1:0];
        ln.end_y       = ey[COORD_W-1:0];
        ln.start_color = c0[COLOR_W-1:0];
        ln.end_color   = c1[COLOR_W-1:0];
        send_line(ln);
    endtask

    // stop offering, wait for every predicted pixel, then let a clipped line finish
    task automatic drain_pixels();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_screen(int unsigned value);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value[SCR_W-1:0];
        @(posedge i_clk);
        sb.set_screen(value);
        i_cfg_wen   <= 1'b0;
        screens_tried++;
    endtask

    // mostly lines near the screen, some across the whole coordinate range,
    // plus zero-length lines and exact diagonals
    function automatic line_t random_line(int unsigned screen);
        line_t ln;
        int    kind, lo, hi, d, sx, sy, ex, ey;
        kind = $urandom_range(0, 99);
        lo   = -16;
        hi   = ((screen < 8) ? 8 : ((screen > 64) ? 64 : screen)) + 15;
        sx   = lo + int'($urandom_range(0, hi - lo));
        sy   = lo + int'($urandom_range(0, hi - lo));
        ex   = lo + int'($urandom_range(0, hi - lo));
        ey   = lo + int'($urandom_range(0, hi - lo));
        if (kind < 15) begin
            sx = int'($urandom_range(0, 511)) - 256;
            sy = int'($urandom_range(0, 511)) - 256;
            ex = int'($urandom_range(0, 511)) - 256;
            ey = int'($urandom_range(0, 511)) - 256;
        end else if (kind < 22) begin
            ex = sx;
            ey = sy;
        end else if (kind < 30) begin
            d  = $urandom_range(0, 40);
            ex = $urandom_range(0, 1) ? sx + d : sx - d;
            ey = $urandom_range(0, 1) ? sy + d : sy - d;
        end
        ln.start_x     = sx[COORD_W-1:0];
        ln.start_y     = sy[COORD_W-1:0];
        ln.end_x       = ex[COORD_W-1:0];
        ln.end_y       = ey[COORD_W-1:0];
        ln.start_color = COLOR_W'($urandom_range(0, 255));
        ln.end_color   = COLOR_W'($urandom_range(0, 255));
        return ln;
    endfunction

    // receiver: random stall bursts and ready stretches, one long hold-off on request
    initial begin
        int stall_left = 0;
        int run_left   = 0;
        int hold_left  = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (quiet_tail) begin
                m_axis_tready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (run_left > 0) begin
                run_left--;
                m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                stall_left = $urandom_range(1, 10) - 1;
                m_axis_tready <= 1'b0;
            end else begin
                run_left = $urandom_range(1, 40);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // pixel monitor, sampled at the edge so it sees pre-edge values
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_pixel({m_axis_tlast, m_axis_tdata[19:12], m_axis_tdata[11:6],
                            m_axis_tdata[5:0]});
        end
    end

    // watchdog on cycles where no item moves on either side
    initial begin
        int quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
                (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
        $display("%0t: timeout, nothing moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("line_rasterizer_color_interp_core test failed");
        $finish;
    end

    // main sequence
    initial begin
        int unsigned screen;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed lines on the reset screen of 64
        send_coords(  10,   20,   10,   20,  77, 200);  // zero length, visible
        send_coords(  -5,    3,   -5,    3,  12,  34);  // zero length, off screen
        send_coords(   0,    5,   63,    5,   0, 255);  // full-width horizontal
        send_coords(  63,   40,    0,   40, 255,   0);  // reversed endpoints
        send_coords(   7,    0,    7,   63,  10, 250);  // vertical, steep
        send_coords(  50,   63,   45,    0, 200,   3);  // steep and reversed
        send_coords(   0,    0,   63,   63,   0, 255);  // equal spans stay shallow
        send_coords(  63,    0,    0,   63, 128,  64);
        send_coords(-256, -256,  255,  255,   0, 255);  // coordinate extremes
        send_coords( 255, -256, -256,  255, 255,   0);
        send_coords(-256,   30,  255,   31, 100, 101);
        send_coords(-100,  -50,  -10,  -90,  40,  80);  // fully clipped
        send_coords(  64,   64,  200,   70,  90,  91);  // just past the far edges
        send_coords(   0,  -10,   63,   20,   5, 250);  // minor axis enters the screen
        send_coords(   0,   -3,   10,    4, 255,   1);  // negative minor truncates to zero
        send_coords(  20,   10,   23,   60, 255,   0);
        send_coords(  30,   30,   31,   30,   0,   1);  // span of one
        send_coords(   5,    5,    4,    6,  33,  66);
        send_coords(  -1,   -1,   64,   64, 250,  10);  // both screen borders
        send_coords(  62,    1,    0,    0,   1, 254);
        send_coords(   0,   63,   63,   62, 255, 255);

        // random phases, each on its own screen size written while idle
        for (int p = 0; p < N_PHASES; p++) begin
            drain_pixels();
            screen = (p == N_PHASES - 1) ? $urandom_range(3, 63) : SCREEN_PLAN[p];
            write_screen(screen);
            if (p == N_PHASES - 1) quiet_tail = 1'b1;
            if (p == 0) begin
                // long receiver hold-off while lines keep coming back to back
                hold_req = 1'b1;
                gaps_on  = 1'b0;
            end
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 0 && k == 6) gaps_on = 1'b1;
                send_line(random_line(screen));
            end
        end

        drain_pixels();
        if (sb.pending() != 0) begin
            sb.errors++;
            $display("%0t: %0d pixels never arrived", $time, sb.pending());
        end
        $display("ran %0d lines (%0d fully off screen) and checked %0d pixels",
                 sb.lines_seen, sb.lines_blank, sb.pixels_checked);
        $display("screen sizes written: %0d, including 0, 1 and the oversized 127",
                 screens_tried);
        if (sb.errors == 0) begin
            $display("line_rasterizer_color_interp_core test passed");
        end else begin
            $display("line_rasterizer_color_interp_core test failed");
        end
        $finish;
    end

endmodule
